### rtl/core/awsf_pkg.sv
// Shared types and constants for the ALU with status flags.
// Used by the divide step stage and the top level; depends on nothing.
package awsf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 4;
  localparam int unsigned ShW   = 5;

  // Operation codes carried in the input tuser.
  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_SLL = 4'd7,
    OP_SRL = 4'd8,
    OP_SRA = 4'd9
  } op_t;

  // Payload that travels down the pipeline with each word.
  typedef struct packed {
    logic [OpW-1:0]     op;
    logic               sa;       // sign of operand a
    logic               sb;       // sign of operand b
    logic               fsa;      // operand sign used by the overflow flag
    logic               fsb;
    logic               dz;       // divide by zero
    logic [DataW-1:0]   a;        // dividend, kept for divide by zero
    logic [DataW-1:0]   simple;   // add, sub, logic and shift result
    logic [2*DataW-1:0] prod;     // unsigned magnitude product
    logic [DataW-1:0]   divisor;  // magnitude of b
    logic [DataW-1:0]   rem;      // partial remainder
    logic [DataW-1:0]   dq;       // dividend bits shifting out, quotient in
  } stage_t;

endpackage

### rtl/core/alu_with_status_flags_unit.sv
// Top level of the pipelined 32-bit ALU with status flags.
// Depends on awsf_pkg and instantiates awsf_div_stage for the divider.
//
// Channel | Dir | Handshake         | Payload
// s       | in  | s_tvalid/s_tready | tuser: req_type; tdata: operand_a, operand_b
// m       | out | m_tvalid/m_tready | tdata: result, hi, lo, hilo_write, flags
//
// One word is accepted per cycle while the output word is not held. Every operation
// reaches the output through the input register, loaded at the accepting edge, then
// the 32 one-bit divide stages and the output register. The multiplier sits in the
// first divide stage.
// Reset clears only the valid bits. When the output word is held, the whole
// pipeline holds and s_tready drops; nothing is lost or repeated.
module alu_with_status_flags_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [3:0]   s_tuser,   // req_type
  input  logic [71:0]  s_tdata,   // operand_a, operand_b, zero fill
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // result_word, hi_word, lo_word, hilo_write,
                                  // carry, overflow, sign, zero, divide_by_zero,
                                  // zero fill
);
  import awsf_pkg::*;

  localparam int unsigned Steps = DataW;

  logic                en;
  logic [DataW-1:0]    a, b, ma, mb;
  logic [ShW-1:0]      sh;
  logic [OpW-1:0]      op_in;
  logic [DataW-1:0]    simple;
  stage_t              s0_next;
  logic                v0;
  stage_t              st0;
  logic                v [1:Steps];
  stage_t              st [1:Steps];
  stage_t              first_in;

  // The pipeline advances whenever the output register can take a word.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign op_in = s_tuser;
  assign a     = s_tdata[DataW-1:0];
  assign b     = s_tdata[2*DataW-1:DataW];
  assign sh    = b[ShW-1:0];
  assign ma    = a[DataW-1] ? (~a + 1'b1) : a;
  assign mb    = b[DataW-1] ? (~b + 1'b1) : b;

  // Add, sub, logic and shift results and operand magnitudes.
  always_comb begin
    case (op_in)
      OP_ADD:  simple = a + b;
      OP_SUB:  simple = a - b;
      OP_AND:  simple = a & b;
      OP_OR:   simple = a | b;
      OP_XOR:  simple = a ^ b;
      OP_SLL:  simple = a << sh;
      OP_SRL:  simple = a >> sh;
      OP_SRA:  simple = DataW'($signed(a) >>> sh);
      default: simple = '0;
    endcase
    s0_next.op      = op_in;
    s0_next.sa      = a[DataW-1];
    s0_next.sb      = b[DataW-1];
    s0_next.fsa     = (op_in == OP_DIV) ? ma[DataW-1] : a[DataW-1];
    s0_next.fsb     = (op_in == OP_DIV) ? mb[DataW-1] : b[DataW-1];
    s0_next.dz      = (op_in == OP_DIV) && (b == '0);
    s0_next.a       = a;
    s0_next.simple  = simple;
    s0_next.prod    = '0;
    s0_next.divisor = mb;
    s0_next.rem     = '0;
    s0_next.dq      = ma;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0 <= s0_next;
    end
  end

  // The unsigned multiply runs beside the first divide step.
  always_comb begin
    first_in      = st0;
    first_in.prod = st0.dq * st0.divisor;
  end

  // Divider chain, one quotient bit per stage.
  for (genvar i = 0; i < Steps; i++) begin : g_div
    logic   in_v;
    stage_t in_d;
    if (i == 0) begin : g_first
      assign in_v = v0;
      assign in_d = first_in;
    end else begin : g_rest
      assign in_v = v[i];
      assign in_d = st[i];
    end
    awsf_div_stage u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (in_v),
      .in_data  (in_d),
      .out_valid(v[i+1]),
      .out_data (st[i+1])
    );
  end

  // Sign correction, result selection and flags.
  stage_t           f;
  logic [2*DataW-1:0] sprod;
  logic [DataW-1:0] r, hi, lo;
  logic             hw, cf, of, sr, known;

  always_comb begin
    f     = st[Steps];
    sprod = (f.sa ^ f.sb) ? (~f.prod + 1'b1) : f.prod;
    r     = f.simple;
    hi    = '0;
    lo    = '0;
    hw    = 1'b0;
    known = 1'b1;
    case (f.op)
      OP_MUL: begin
        hi = sprod[2*DataW-1:DataW];
        lo = sprod[DataW-1:0];
        r  = lo;
        hw = 1'b1;
      end
      OP_DIV: begin
        if (f.dz) begin
          hi = f.a;
          lo = '0;
        end else begin
          lo = (f.sa ^ f.sb) ? (~f.dq + 1'b1) : f.dq;
          hi = f.sa ? (~f.rem + 1'b1) : f.rem;
        end
        r  = lo;
        hw = 1'b1;
      end
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SLL, OP_SRL, OP_SRA: begin
        known = 1'b1;
      end
      default: known = 1'b0;
    endcase
    sr = r[DataW-1];
    cf = (f.op == OP_SUB) ? (!f.sa && !f.sb && sr) : sr;
    of = (f.fsa == f.fsb) && (sr != f.fsa);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (known) begin
        m_tdata <= {2'b00, f.dz, (r == '0), sr, of, cf, hw, lo, hi, r};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // A divide by zero reports quotient zero with hi and lo written.
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[101] |-> (m_tdata[31:0] == '0) && m_tdata[96])
    else $error("divide by zero word has nonzero quotient or no hi/lo write");

  // Without a hi/lo write, hi and lo stay zero.
  a_hilo_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[96] |-> (m_tdata[95:32] == '0))
    else $error("hi/lo nonzero without hilo_write");

  // A held output word does not change until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // The input side is stalled whenever the output word is held.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while pipeline is stalled");

endmodule

### rtl/core/awsf_div_stage.sv
// One restoring-division step followed by a pipeline register.
// Depends on awsf_pkg for the stage payload type.
module awsf_div_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  awsf_pkg::stage_t in_data,
  output logic            out_valid,
  output awsf_pkg::stage_t out_data
);
  import awsf_pkg::*;

  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;
  stage_t           step;

  // Shift the next dividend bit into the remainder and try the subtraction.
  always_comb begin
    trial = {in_data.rem, in_data.dq[DataW-1]};
    diff  = trial - {1'b0, in_data.divisor};
    ge    = (trial >= {1'b0, in_data.divisor});
    step  = in_data;
    step.rem = ge ? diff[DataW-1:0] : trial[DataW-1:0];
    step.dq  = {in_data.dq[DataW-2:0], ge};
  end

  // Valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= step;
    end
  end

endmodule
